FILE: rtl/rfbhs_pkg.sv
// ----------------------------------------------------------------------------
// RFB handshake parser package
// Phase codes, event and reply codes, and the layout of a result.
// ----------------------------------------------------------------------------
package rfbhs_pkg;

  localparam int unsigned PHASE_W = 6;

  localparam logic [PHASE_W-1:0] PH_GREET_START = 6'd0;
  localparam logic [PHASE_W-1:0] PH_GREET_END   = 6'd11;
  localparam logic [PHASE_W-1:0] PH_SEC33       = 6'd12;
  localparam logic [PHASE_W-1:0] PH_SEC33_LAST  = 6'd15;
  localparam logic [PHASE_W-1:0] PH_ERRLEN      = 6'd16;
  localparam logic [PHASE_W-1:0] PH_ERRLEN_LAST = 6'd19;
  localparam logic [PHASE_W-1:0] PH_ERRTXT      = 6'd20;
  localparam logic [PHASE_W-1:0] PH_RESULT      = 6'd21;
  localparam logic [PHASE_W-1:0] PH_RESULT_LAST = 6'd24;
  localparam logic [PHASE_W-1:0] PH_LISTLEN     = 6'd25;
  localparam logic [PHASE_W-1:0] PH_LIST        = 6'd26;
  localparam logic [PHASE_W-1:0] PH_INIT        = 6'd27;
  localparam logic [PHASE_W-1:0] PH_WIDTH_HI    = 6'd27;
  localparam logic [PHASE_W-1:0] PH_WIDTH_LO    = 6'd28;
  localparam logic [PHASE_W-1:0] PH_HEIGHT_HI   = 6'd29;
  localparam logic [PHASE_W-1:0] PH_HEIGHT_LO   = 6'd30;
  localparam logic [PHASE_W-1:0] PH_NLEN_FIRST  = 6'd47;
  localparam logic [PHASE_W-1:0] PH_NLEN_LAST   = 6'd50;
  localparam logic [PHASE_W-1:0] PH_NAME        = 6'd51;
  localparam logic [PHASE_W-1:0] PH_DONE        = 6'd52;
  localparam logic [PHASE_W-1:0] PH_ABORT       = 6'd53;

  localparam logic [3:0] EV_NONE       = 4'd0;
  localparam logic [3:0] EV_GREET_CHAR = 4'd1;
  localparam logic [3:0] EV_LIST_BEGIN = 4'd2;
  localparam logic [3:0] EV_SEC_TYPE   = 4'd3;
  localparam logic [3:0] EV_ERR_BEGIN  = 4'd4;
  localparam logic [3:0] EV_ERR_CHAR   = 4'd5;
  localparam logic [3:0] EV_WIDTH      = 4'd6;
  localparam logic [3:0] EV_HEIGHT     = 4'd7;
  localparam logic [3:0] EV_NAME_BEGIN = 4'd8;
  localparam logic [3:0] EV_NAME_CHAR  = 4'd9;

  localparam logic [2:0] SEND_NONE    = 3'd0;
  localparam logic [2:0] SEND_VER_33  = 3'd1;
  localparam logic [2:0] SEND_VER_37  = 3'd2;
  localparam logic [2:0] SEND_VER_38  = 3'd3;
  localparam logic [2:0] SEND_ONE     = 3'd4;
  localparam logic [2:0] SEND_ONE_ONE = 3'd5;

  localparam logic [7:0] NEWLINE      = 8'h0A;
  localparam logic [3:0] MINOR_37     = 4'd7;
  localparam logic [3:0] MINOR_MOD    = 4'd10;

  // Bit positions of the result fields inside out_tdata.
  localparam int unsigned OD_SEND_LSB = 32;
  localparam int unsigned OD_CLOSE    = 35;
  localparam int unsigned OD_STOP     = 36;
  localparam int unsigned OUT_DATA_W  = 40;

  typedef struct packed {
    logic [3:0]  event_kind;
    logic [31:0] event_value;
    logic        group_end;
    logic [2:0]  send_code;
    logic        close_conn;
    logic        stopped;
  } result_t;

endpackage

FILE: rtl/rfb_handshake_banner_parser.sv
// ----------------------------------------------------------------------------
// RFB handshake banner parser
// Follows the server side of a VNC client handshake one byte at a time and
// reports one event, reply code and close request per byte.
// ----------------------------------------------------------------------------
// Usage:
// The in_ stream carries one server byte per request in in_tdata[7:0]. The
// in_tuser bit restarts the parse at the greeting before that byte is taken,
// and in_tlast marks the end of a received segment without affecting parsing.
// Every accepted byte produces exactly one request on the out_ stream: the
// event kind in out_tuser, the event value, reply code, close and stopped
// flags in out_tdata, and the end of an auth list or name on out_tlast.
// The result is registered and appears in the cycle after the byte is accepted.
// One byte per cycle is sustained while out_tready is high; the phase register and
// the 32-bit count update together in the accepting cycle, and the output register
// lets the next byte in while a result is taken. When the receiver stalls, in_tready
// drops only while the output register is full and out_tready is low.
// Reset clears the parse state to the first greeting byte, sets the client minor
// version to zero and empties the output register. cfg_wr_en writes the client minor
// version. The user must write it only while no request is in flight; not enforced.
// ----------------------------------------------------------------------------
module rfb_handshake_banner_parser
  import rfbhs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [3:0]            cfg_wr_data,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] data_byte
  input  logic                  in_tlast,   // segment_last
  input  logic [0:0]            in_tuser,   // [0] conn_start
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [31:0] event_value, [34:32] send_code, [35] close_conn, [36] stopped, [39:37] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast,  // group_end
  output logic [3:0]            out_tuser   // [3:0] event_kind
);

  logic [3:0]         minor_r;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [31:0]        count_r, count_nxt;
  logic [7:0]         list_rem_r, list_rem_nxt;
  logic [7:0]         high_byte_r, high_byte_nxt;
  logic               out_valid_r;
  result_t            res_r, res_nxt;

  logic               in_fire;
  logic [PHASE_W-1:0] ph_cur;
  logic [31:0]        cnt_cur;
  logic [7:0]         lrem_cur;
  logic [7:0]         hb_cur;
  logic [7:0]         b;
  logic [31:0]        cnt_shift;
  logic [31:0]        cnt_first;
  logic [31:0]        cnt_dec;
  logic [7:0]         lrem_dec;
  logic [3:0]         minor_mod;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign b         = in_tdata;

  // The restart flag clears the parse state before the byte is parsed.
  assign ph_cur    = in_tuser[0] ? PH_GREET_START : phase_r;
  assign cnt_cur   = in_tuser[0] ? 32'd0 : count_r;
  assign lrem_cur  = in_tuser[0] ? 8'd0 : list_rem_r;
  assign hb_cur    = in_tuser[0] ? 8'd0 : high_byte_r;

  assign cnt_shift = {cnt_cur[23:0], b};
  assign cnt_first = {24'd0, b};
  assign cnt_dec   = cnt_cur - 32'd1;
  assign lrem_dec  = lrem_cur - 8'd1;
  assign minor_mod = (minor_r >= MINOR_MOD) ? (minor_r - MINOR_MOD) : minor_r;

  always_comb begin
    phase_nxt     = ph_cur;
    count_nxt     = cnt_cur;
    list_rem_nxt  = lrem_cur;
    high_byte_nxt = hb_cur;
    res_nxt       = '0;

    if (ph_cur < PH_GREET_END) begin
      res_nxt.event_kind  = EV_GREET_CHAR;
      res_nxt.event_value = cnt_first;
      phase_nxt           = ph_cur + 6'd1;
    end else if (ph_cur == PH_GREET_END) begin
      if (b == NEWLINE) begin
        if (minor_mod < MINOR_37) begin
          res_nxt.send_code = SEND_VER_33;
          phase_nxt         = PH_SEC33;
        end else begin
          res_nxt.send_code = (minor_mod == MINOR_37) ? SEND_VER_37 : SEND_VER_38;
          phase_nxt         = PH_LISTLEN;
        end
      end else begin
        res_nxt.close_conn = 1'b1;
        phase_nxt          = PH_ABORT;
      end
    end else if (ph_cur inside {[PH_SEC33:PH_SEC33_LAST]}) begin
      count_nxt = (ph_cur == PH_SEC33) ? cnt_first : cnt_shift;
      if (ph_cur == PH_SEC33_LAST) begin
        res_nxt.event_kind  = EV_SEC_TYPE;
        res_nxt.event_value = count_nxt;
        res_nxt.group_end   = 1'b1;
        if (count_nxt == 32'd0) begin
          phase_nxt = PH_ERRLEN;
        end else if (count_nxt == 32'd1) begin
          res_nxt.send_code = SEND_ONE;
          phase_nxt         = PH_INIT;
        end else begin
          res_nxt.close_conn = 1'b1;
          phase_nxt          = PH_DONE;
        end
      end else begin
        phase_nxt = ph_cur + 6'd1;
      end
    end else if (ph_cur inside {[PH_ERRLEN:PH_ERRLEN_LAST]}) begin
      count_nxt = (ph_cur == PH_ERRLEN) ? cnt_first : cnt_shift;
      if (ph_cur == PH_ERRLEN_LAST) begin
        res_nxt.event_kind  = EV_ERR_BEGIN;
        res_nxt.event_value = count_nxt;
      end
      phase_nxt = ph_cur + 6'd1;
    end else if (ph_cur == PH_ERRTXT) begin
      if (cnt_cur == 32'd0) begin
        res_nxt.close_conn = 1'b1;
        phase_nxt          = PH_DONE;
      end else begin
        count_nxt           = cnt_dec;
        res_nxt.event_kind  = EV_ERR_CHAR;
        res_nxt.event_value = cnt_first;
      end
    end else if (ph_cur inside {[PH_RESULT:PH_RESULT_LAST]}) begin
      count_nxt = (ph_cur == PH_RESULT) ? cnt_first : cnt_shift;
      if (ph_cur == PH_RESULT_LAST) begin
        if (count_nxt == 32'd0) begin
          res_nxt.send_code = SEND_ONE;
          phase_nxt         = PH_INIT;
        end else begin
          phase_nxt = PH_ERRLEN;
        end
      end else begin
        phase_nxt = ph_cur + 6'd1;
      end
    end else if (ph_cur == PH_LISTLEN) begin
      list_rem_nxt = b;
      if (b == 8'd0) begin
        phase_nxt = PH_ERRLEN;
      end else begin
        res_nxt.event_kind  = EV_LIST_BEGIN;
        res_nxt.event_value = cnt_first;
        phase_nxt           = PH_LIST;
      end
    end else if (ph_cur == PH_LIST) begin
      if (lrem_cur != 8'd0) begin
        list_rem_nxt        = lrem_dec;
        res_nxt.event_kind  = EV_SEC_TYPE;
        res_nxt.event_value = cnt_first;
      end
      if (list_rem_nxt == 8'd0) begin
        res_nxt.group_end = 1'b1;
        if (minor_r < MINOR_37) begin
          res_nxt.send_code = SEND_ONE;
          phase_nxt         = PH_INIT;
        end else if (minor_r == MINOR_37) begin
          res_nxt.send_code = SEND_ONE_ONE;
          phase_nxt         = PH_INIT;
        end else begin
          res_nxt.send_code = SEND_ONE;
          phase_nxt         = PH_RESULT;
        end
      end
    end else if (ph_cur inside {[PH_INIT:PH_NLEN_LAST]}) begin
      phase_nxt = ph_cur + 6'd1;
      if (ph_cur == PH_WIDTH_HI || ph_cur == PH_HEIGHT_HI) begin
        high_byte_nxt = b;
      end else if (ph_cur == PH_WIDTH_LO || ph_cur == PH_HEIGHT_LO) begin
        res_nxt.event_kind  = (ph_cur == PH_WIDTH_LO) ? EV_WIDTH : EV_HEIGHT;
        res_nxt.event_value = {16'd0, hb_cur, b};
      end else if (ph_cur == PH_NLEN_FIRST) begin
        count_nxt = cnt_first;
      end else if (ph_cur > PH_NLEN_FIRST) begin
        count_nxt = cnt_shift;
        if (ph_cur == PH_NLEN_LAST) begin
          if (count_nxt != 32'd0) begin
            res_nxt.event_kind  = EV_NAME_BEGIN;
            res_nxt.event_value = count_nxt;
          end else begin
            res_nxt.close_conn = 1'b1;
            phase_nxt          = PH_DONE;
          end
        end
      end
    end else if (ph_cur == PH_NAME) begin
      count_nxt           = cnt_dec;
      res_nxt.event_kind  = EV_NAME_CHAR;
      res_nxt.event_value = cnt_first;
      if (cnt_dec == 32'd0) begin
        res_nxt.group_end  = 1'b1;
        res_nxt.close_conn = 1'b1;
        phase_nxt          = PH_DONE;
      end
    end else if (ph_cur == PH_DONE) begin
      res_nxt.stopped    = 1'b1;
      res_nxt.close_conn = 1'b1;
    end else begin
      res_nxt.stopped = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      minor_r     <= '0;
      phase_r     <= PH_GREET_START;
      count_r     <= '0;
      list_rem_r  <= '0;
      high_byte_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        minor_r <= cfg_wr_data;
      end
      if (in_fire) begin
        phase_r     <= phase_nxt;
        count_r     <= count_nxt;
        list_rem_r  <= list_rem_nxt;
        high_byte_r <= high_byte_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.event_kind;
  assign out_tlast  = res_r.group_end;
  assign out_tdata  = {3'b000, res_r.stopped, res_r.close_conn, res_r.send_code,
                       res_r.event_value};

endmodule

FILE: rtl/rfbhs_checker.sv
// ----------------------------------------------------------------------------
// RFB handshake parser port checker
// Watches the streaming ports of the parser and flags inconsistent results.
// ----------------------------------------------------------------------------
module rfbhs_checker
  import rfbhs_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tlast,
  input logic [3:0]            out_tuser
);

  // A stalled result keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  // Every accepted byte yields a result in the next cycle.
  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted byte gave no result");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // A group ends only on a security type or a name character.
  a_group_end_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> (out_tuser == EV_SEC_TYPE || out_tuser == EV_NAME_CHAR))
    else $error("group end on wrong event");

  // An ignored byte carries no event and no reply.
  a_stopped_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[OD_STOP] |-> out_tuser == EV_NONE
      && out_tdata[OD_SEND_LSB+2:OD_SEND_LSB] == SEND_NONE && out_tdata[31:0] == 32'd0)
    else $error("stopped result carries data");

endmodule

bind rfb_handshake_banner_parser rfbhs_checker u_rfbhs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
